// ===== design/tach_pkg.sv =====
// Shared types, constants and register codes of the pulse-period tachometer.
package tach_pkg;

  localparam int TS_W      = 32;
  localparam int RPM_W     = 16;
  localparam int TURNS_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // 60000000 * 15 stays below 2**30, so the dividend needs 30 bits.
  localparam int NUM_W     = 30;
  localparam int unsigned USEC_PER_MINUTE = 60000000;

  localparam int TACH_RING_DEPTH = 8;

  localparam logic [TS_W-1:0]    MIN_INTERVAL_RESET = TS_W'(1000);
  localparam logic [TS_W-1:0]    MAX_INTERVAL_RESET = TS_W'(1000000);
  localparam logic [TURNS_W-1:0] TURNS_RESET        = TURNS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_MAX_INTERVAL = 2'd1,
    CFG_TURNS        = 2'd2
  } tach_reg_t;

  typedef struct packed {
    logic [TS_W-1:0]    min_interval_us;
    logic [TS_W-1:0]    max_interval_us;
    logic [TURNS_W-1:0] turns_per_window;
  } tach_cfg_t;

endpackage

// ===== design/tach_pulse_if.sv =====
// Channel carrying one timestamped rising edge of the pulse line.
interface tach_pulse_if;
  import tach_pkg::*;

  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp_us;

  modport source (output valid, output timestamp_us, input ready);
  modport sink (input valid, input timestamp_us, output ready);
endinterface

// ===== design/tach_result_if.sv =====
// Channel carrying one speed result.
interface tach_result_if;
  import tach_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic [RPM_W-1:0] rpm;
  logic             zero_window;
  logic             saturated;

  modport source (output valid, output accepted, output rpm, output zero_window,
                  output saturated, input ready);
  modport sink (input valid, input accepted, input rpm, input zero_window,
                input saturated, output ready);
endinterface

// ===== design/tach_cfg_if.sv =====
// Register write channel of the tachometer.
interface tach_cfg_if;
  import tach_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/tach_queue.sv =====
// Two-entry queue between the edge front end and the divider back end.
module tach_queue #(
  parameter int WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/tach_front.sv =====
// Edge front end: interval, bounce check, interval ring and running sum.
module tach_front #(
  parameter int RING_DEPTH = tach_pkg::TACH_RING_DEPTH,
  parameter int SUM_W      = tach_pkg::TS_W + $clog2(RING_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  tach_pkg::tach_cfg_t cfg,
  tach_pulse_if.sink          pulse,
  output logic                q_push,
  output logic [SUM_W:0]      q_data,
  input  logic                q_full
);
  import tach_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHECK,
    F_UPDATE,
    F_PUSH
  } front_state_t;

  front_state_t          state;
  logic [IDX_W-1:0]      write_index;
  logic [IDX_W-1:0]      idx_inc;
  logic [TS_W-1:0]       last_edge;
  logic [TS_W-1:0]       edge_time;
  logic [TS_W-1:0]       interval;
  logic [TS_W-1:0]       stored;
  logic                  pass;
  logic [SUM_W-1:0]      window_sum;
  logic [SUM_W-1:0]      old_value;
  logic [RING_DEPTH-1:0] ring_valid;
  logic                  rd_valid;
  logic [TS_W-1:0]       rd_data;
  logic [TS_W-1:0]       ring_mem [RING_DEPTH];

  assign idx_inc     = (write_index == IDX_W'(RING_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign old_value   = rd_valid ? SUM_W'(rd_data) : '0;
  assign pulse.ready = (state == F_IDLE);
  assign q_push      = (state == F_PUSH);
  assign q_data      = {pass, window_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      write_index <= '0;
      last_edge   <= '0;
      window_sum  <= '0;
      ring_valid  <= '0;
      rd_valid    <= 1'b0;
      pass        <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (pulse.valid) begin
            interval  <= pulse.timestamp_us - last_edge;
            edge_time <= pulse.timestamp_us;
            state     <= F_CHECK;
          end
        end
        F_CHECK: begin
          pass     <= (interval >= cfg.min_interval_us);
          stored   <= (interval > cfg.max_interval_us) ? '0 : interval;
          rd_valid <= ring_valid[idx_inc];
          state    <= (interval >= cfg.min_interval_us) ? F_UPDATE : F_PUSH;
        end
        F_UPDATE: begin
          window_sum           <= window_sum - old_value + SUM_W'(stored);
          write_index          <= idx_inc;
          ring_valid[idx_inc]  <= 1'b1;
          last_edge            <= edge_time;
          state                <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_CHECK) begin
      rd_data <= ring_mem[idx_inc];
    end
    if (state == F_UPDATE) begin
      ring_mem[idx_inc] <= stored;
    end
  end

endmodule

// ===== design/tach_back.sv =====
// Divider back end: bit-serial speed division, clamping and result register.
module tach_back #(
  parameter int SUM_W = tach_pkg::TS_W + $clog2(tach_pkg::TACH_RING_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  tach_pkg::tach_cfg_t cfg,
  input  logic                q_empty,
  input  logic [SUM_W:0]      q_data,
  output logic                q_pop,
  tach_result_if.source       result
);
  import tach_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

  back_state_t      state;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] divisor;
  logic [SUM_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic             acc_hold;
  logic             zero_hold;
  logic [SUM_W:0]   rem_shift;
  logic [SUM_W:0]   rem_diff;
  logic             rem_ge;
  logic             out_valid;
  logic             out_accepted;
  logic [RPM_W-1:0] out_rpm;
  logic             out_zero;
  logic             out_sat;
  logic             out_free;
  logic             quo_high;

  assign rem_shift = {rem, quo[NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign out_free  = !out_valid || result.ready;
  assign quo_high  = |quo[NUM_W-1:RPM_W];
  assign q_pop     = (state == B_IDLE) && !q_empty;

  assign result.valid       = out_valid;
  assign result.accepted    = out_accepted;
  assign result.rpm         = out_rpm;
  assign result.zero_window = out_zero;
  assign result.saturated   = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (state == B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            acc_hold  <= q_data[SUM_W];
            divisor   <= q_data[SUM_W-1:0];
            zero_hold <= (q_data[SUM_W-1:0] == '0);
            rem       <= '0;
            quo       <= NUM_W'(USEC_PER_MINUTE * cfg.turns_per_window);
            count     <= '0;
            state     <= (q_data[SUM_W-1:0] == '0) ? B_OUT : B_DIV;
          end
        end
        B_DIV: begin
          rem   <= rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
          quo   <= {quo[NUM_W-2:0], rem_ge};
          count <= count + 1'b1;
          if (count == CNT_W'(NUM_W - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_accepted <= acc_hold;
            out_zero     <= zero_hold;
            out_sat      <= !zero_hold && quo_high;
            if (zero_hold) begin
              out_rpm <= '0;
            end else if (quo_high) begin
              out_rpm <= '1;
            end else begin
              out_rpm <= quo[RPM_W-1:0];
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pulse_period_tachometer.sv =====
// Path: an edge moves from F_IDLE through F_CHECK, and F_UPDATE when it updates the ring,
// to F_PUSH and the queue; the back end loads it in B_IDLE, forms 30 quotient bits in B_DIV
// and registers the result in B_OUT; a zero sum skips the divide and goes straight to B_OUT.
// The 30-step bit-serial divider takes no new queue entry until B_OUT has registered its result.
// Reset: synchronous rst restores the register values, clears the ring valid bits, index,
// sum and queue; unwritten ring entries read as zero, so no clearing pass is needed.
module pulse_period_tachometer #(
  parameter int RING_DEPTH = tach_pkg::TACH_RING_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  tach_cfg_if.sink      cfg,
  tach_pulse_if.sink    pulse,
  tach_result_if.source result
);
  import tach_pkg::*;

  localparam int SUM_W = TS_W + $clog2(RING_DEPTH);

  tach_cfg_t      regs;
  logic           q_push;
  logic [SUM_W:0] q_push_data;
  logic           q_full;
  logic           q_pop;
  logic [SUM_W:0] q_pop_data;
  logic           q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_interval_us  <= MIN_INTERVAL_RESET;
      regs.max_interval_us  <= MAX_INTERVAL_RESET;
      regs.turns_per_window <= TURNS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MIN_INTERVAL: regs.min_interval_us  <= cfg.data[TS_W-1:0];
        CFG_MAX_INTERVAL: regs.max_interval_us  <= cfg.data[TS_W-1:0];
        CFG_TURNS:        regs.turns_per_window <= cfg.data[TURNS_W-1:0];
        default:          regs <= regs;
      endcase
    end
  end

  tach_front #(
    .RING_DEPTH (RING_DEPTH),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (regs),
    .pulse  (pulse),
    .q_push (q_push),
    .q_data (q_push_data),
    .q_full (q_full)
  );

  tach_queue #(
    .WIDTH (SUM_W + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  tach_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

// ===== bench/tach_speed_checker.sv =====
// Checker that predicts every speed result of the pulse-period tachometer and compares it.
`timescale 1ns / 1ps

module tach_speed_checker
  import tach_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tach_cfg_if         cfg,
  tach_pulse_if       pulse,
  tach_result_if      result,
  output int          mismatches,
  output int          results_due,
  output int          results_seen
);

  localparam int SUM_W = TS_W + $clog2(TACH_RING_DEPTH);
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic             accepted;
    logic [RPM_W-1:0] rpm;
    logic             zero_window;
    logic             saturated;
  } speed_result_t;

  logic [TS_W-1:0]    bounce_limit;
  logic [TS_W-1:0]    standstill_limit;
  logic [TURNS_W-1:0] turns;

  logic [TS_W-1:0]    interval_hist [TACH_RING_DEPTH];
  int                 hist_pos;
  logic [TS_W-1:0]    prev_edge_us;
  logic [SUM_W-1:0]   hist_total;

  speed_result_t      speed_expected_q[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic speed_result_t register_edge(input logic [TS_W-1:0] now);
    logic [TS_W-1:0] span_us;
    logic [63:0]     quotient;
    speed_result_t   r;
    r = '0;
    span_us = now - prev_edge_us;
    if (span_us >= bounce_limit) begin
      if (span_us > standstill_limit) span_us = '0;
      hist_pos = (hist_pos == TACH_RING_DEPTH - 1) ? 0 : hist_pos + 1;
      hist_total = hist_total - SUM_W'(interval_hist[hist_pos]) + SUM_W'(span_us);
      interval_hist[hist_pos] = span_us;
      prev_edge_us = now;
      r.accepted = 1'b1;
    end
    if (hist_total == '0) begin
      r.zero_window = 1'b1;
    end else begin
      quotient = (64'(USEC_PER_MINUTE) * 64'(turns)) / 64'(hist_total);
      if (quotient > 64'(16'hFFFF)) begin
        r.rpm = '1;
        r.saturated = 1'b1;
      end else begin
        r.rpm = quotient[RPM_W-1:0];
      end
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    results_seen = 0;
    results_due = 0;
  end

  always @(posedge clk) begin
    speed_result_t want;
    if (rst) begin
      bounce_limit = MIN_INTERVAL_RESET;
      standstill_limit = MAX_INTERVAL_RESET;
      turns = TURNS_RESET;
      for (int i = 0; i < TACH_RING_DEPTH; i++) interval_hist[i] = '0;
      hist_pos = 0;
      prev_edge_us = '0;
      hist_total = '0;
      speed_expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MIN_INTERVAL: bounce_limit = cfg.data;
          CFG_MAX_INTERVAL: standstill_limit = cfg.data;
          CFG_TURNS:        turns = cfg.data[TURNS_W-1:0];
          default:          ;
        endcase
      end
      if (pulse.valid && pulse.ready) speed_expected_q.push_back(register_edge(pulse.timestamp_us));
      if (result.valid && result.ready) begin
        results_seen++;
        if (speed_expected_q.size() == 0) begin
          report_mismatch("speed result arrived with no pulse edge waiting for it");
        end else begin
          want = speed_expected_q.pop_front();
          check_field("accepted", result.accepted, want.accepted);
          check_field("rpm", result.rpm, want.rpm);
          check_field("zero_window", result.zero_window, want.zero_window);
          check_field("saturated", result.saturated, want.saturated);
        end
      end
    end
    results_due <= speed_expected_q.size();
  end

endmodule

// ===== bench/tb_pulse_period_tachometer.sv =====
// Top of the tachometer testbench: clock, reset, pulse and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_pulse_period_tachometer;
  import tach_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int END_CYCLES = 48;

  typedef struct {
    logic [TS_W-1:0]    lo;
    logic [TS_W-1:0]    hi;
    logic [TURNS_W-1:0] turns;
    int                 items;
    bit                 idle;
    bit                 hold;
    bit                 junk;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tach_cfg_if    cfg_if ();
  tach_pulse_if  pulse_if ();
  tach_result_if result_if ();

  int mismatches;
  int results_due;
  int results_seen;

  logic [TS_W-1:0] cur_min = MIN_INTERVAL_RESET;
  logic [TS_W-1:0] cur_max = MAX_INTERVAL_RESET;
  logic [TS_W-1:0] last_kept_us = '0;
  bit              tx_idle = 1'b1;
  bit              rx_idle = 1'b1;
  bit              hold_off = 1'b0;
  int              edges_sent = 0;
  int              settings_run = 0;

  always #6 clk = ~clk;

  pulse_period_tachometer uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .pulse  (pulse_if),
    .result (result_if)
  );

  tach_speed_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_if),
    .pulse        (pulse_if),
    .result       (result_if),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= dat;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    if (s.junk) write_reg(CFG_IDX_UNUSED, $urandom);
    write_reg(CFG_MIN_INTERVAL, s.lo);
    write_reg(CFG_MAX_INTERVAL, s.hi);
    write_reg(CFG_TURNS, (32'($urandom) & 32'hFFFF_FFF0) | 32'(s.turns));
    cfg_if.valid <= 1'b0;
    cur_min = s.lo;
    cur_max = s.hi;
  endtask

  task automatic send_stamp(input logic [TS_W-1:0] ts);
    int gap;
    gap = tx_idle ? $urandom_range(6, 0) : 0;
    if (ts - last_kept_us >= cur_min) last_kept_us = ts;
    if (gap > 0) begin
      pulse_if.valid <= 1'b0;
      pulse_if.timestamp_us <= $urandom;
      repeat (gap) @(posedge clk);
    end
    pulse_if.valid <= 1'b1;
    pulse_if.timestamp_us <= ts;
    @(posedge clk);
    while (!pulse_if.ready) @(posedge clk);
    edges_sent++;
  endtask

  function automatic logic [TS_W-1:0] pick_delta();
    int unsigned     pick;
    logic [TS_W-1:0] lo;
    logic [TS_W-1:0] hi;
    pick = $urandom_range(99, 0);
    lo = (cur_min <= cur_max) ? cur_min : cur_max;
    hi = (cur_min <= cur_max) ? cur_max : cur_min;
    if (pick < 12 && cur_min != 0) return $urandom_range(cur_min - 1, 0);
    if (pick < 18) return cur_min;
    if (pick < 22) return cur_max;
    if (pick < 26) return cur_max + 1;
    if (pick < 30) return $urandom;
    if (pick < 36) return $urandom_range(3, 0);
    if (hi - lo > 32'd200000 && $urandom_range(3, 0) != 0) hi = lo + 32'd200000;
    if (hi - lo == '1) return $urandom;
    return $urandom_range(hi, lo);
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic run_setting(input setting_t s);
    apply_setting(s);
    tx_idle = s.idle;
    rx_idle = s.idle;
    if (s.hold) hold_off = 1'b1;
    for (int i = 0; i < s.items; i++) send_stamp(last_kept_us + pick_delta());
    pulse_if.valid <= 1'b0;
    wait_drained();
    settings_run++;
  endtask

  initial begin
    result_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      int wait_n;
      if (hold_off) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = rx_idle ? $urandom_range(6, 0) : 0;
      if (wait_n > 0) begin
        result_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!result_if.valid) @(posedge clk);
    end
  end

  initial begin
    #6_000_000;
    $display("Timeout: the tachometer stopped making progress.");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [TS_W-1:0] opening [10];
    setting_t        plan [6];
    setting_t        s;
    opening = '{32'd0, 32'd999, 32'd1000, 32'd1999, 32'd2000, 32'd1002000, 32'd2002001,
                32'hFFFF_FFF0, 32'h0000_0100, 32'h0000_03D8};
    plan[0] = '{32'd0, 32'hFFFF_FFFF, 4'd15, 200, 1'b1, 1'b1, 1'b0};
    plan[1] = '{32'hFFFF_FFFF, 32'd0, 4'd0, 40, 1'b1, 1'b0, 1'b0};
    plan[2] = '{32'd500, 32'd100, 4'd7, 150, 1'b1, 1'b0, 1'b1};
    plan[3] = '{32'd1000, 32'd1000000, 4'd1, 250, 1'b0, 1'b1, 1'b0};
    plan[4] = '{32'd50, 32'd3000, 4'd15, 250, 1'b1, 1'b0, 1'b0};
    plan[5] = '{32'd0, 32'd0, 4'd3, 80, 1'b1, 1'b0, 1'b0};

    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MIN_INTERVAL;
    cfg_if.data = '0;
    pulse_if.valid = 1'b0;
    pulse_if.timestamp_us = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_stamp(opening[i]);
    for (int i = 0; i < 8; i++) send_stamp(last_kept_us + 32'd1000);
    pulse_if.valid <= 1'b0;
    wait_drained();
    settings_run++;

    foreach (plan[i]) run_setting(plan[i]);
    for (int i = 0; i < 3; i++) begin
      s.lo = $urandom_range(5000, 0);
      s.hi = s.lo + $urandom_range(2000000, 0);
      s.turns = TURNS_W'($urandom_range(15, 0));
      s.items = 220;
      s.idle = 1'b1;
      s.hold = (i == 1);
      s.junk = (i == 2);
      run_setting(s);
    end

    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d pulse edges under %0d register settings: bounce, standstill,",
             edges_sent, settings_run);
    $display("wraparound, saturation, empty window and back-pressure; %0d results compared.",
             results_seen);
    if (mismatches == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
